// File: rtl/core/bsb_pkg.sv
// bsb_pkg: constants, types and controller/datapath links for the
// background subtract bandpass unit; no dependencies
package bsb_pkg;

    localparam int BINS_PER_FRAME = 2048;
    localparam int BIN_W          = $clog2(BINS_PER_FRAME);

    localparam int COEF_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int BG_W     = 32;
    localparam int XH_W     = 25;
    localparam int YH_W     = 40;
    localparam int WIN_W    = 10;
    localparam int FCNT_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W    = 44;
    localparam int DIV_W    = 43;

    localparam int CLAMP_POS     = 29000;
    localparam int SETTLED_COUNT = 301;
    localparam int PASS_BINS     = 3;

    // shared multiplier: 40-bit operand by 17-bit half-coefficient
    localparam int OPA_W  = 40;
    localparam int OPB_W  = 17;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = 62;
    localparam int MUL_OPS   = 18;
    localparam int FILT_LAST = MUL_OPS + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_B0 = 3'd0,
        REG_COEF_B1 = 3'd1,
        REG_COEF_B2 = 3'd2,
        REG_COEF_A1 = 3'd3,
        REG_COEF_A2 = 3'd4,
        REG_COEF_A3 = 3'd5,
        REG_COEF_A4 = 3'd6,
        REG_BG_FRAMES = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_NUM,
        ST_START,
        ST_CALC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear_we;
        logic in_ready;
        logic capture;
        logic prep;
        logic num;
        logic start;
        logic calc;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic calc_done;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/bsb_if.sv
// bsb_if: valid/ready channel interfaces for samples, results and register writes
// depends on bsb_pkg
interface bsb_in_if;
    import bsb_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
    modport source (output valid, output sample, output frame_end, input ready);
    modport sink (input valid, input sample, input frame_end, output ready);
endinterface

interface bsb_out_if;
    import bsb_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       frame_done;
    modport source (output valid, output filtered, output frame_done, input ready);
    modport sink (input valid, input filtered, input frame_done, output ready);
endinterface

interface bsb_cfg_if;
    import bsb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/bsb_ram.sv
// bsb_ram: generic single-port ram with registered read
// no dependencies
module bsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/core/bsb_div.sv
// bsb_div: restoring divider, one quotient bit per cycle, signed result
// depends on bsb_pkg
module bsb_div
    import bsb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DIV_W-1:0]       dividend,
    input  logic                   neg,
    input  logic [WIN_W-1:0]       divisor,
    output logic                   busy,
    output logic signed [BG_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [WIN_W-1:0] rem_reg, rem_next;
    logic [WIN_W-1:0] d_reg, d_next;
    logic             neg_reg, neg_next;
    logic [WIN_W:0]   trial;
    logic [WIN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // magnitude never exceeds 2^31, so the low word carries the signed result
    assign busy     = busy_reg;
    assign quotient = neg_reg ? $signed(BG_W'(0) - q_reg[BG_W-1:0])
                              : $signed(q_reg[BG_W-1:0]);

endmodule

// File: rtl/core/bsb_ctrl.sv
// bsb_ctrl: sequencing state machine for the unit
// depends on bsb_pkg
module bsb_ctrl
    import bsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (sts.clear_last) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_PREP;
            ST_PREP:   state_next = ST_NUM;
            ST_NUM:    state_next = ST_START;
            ST_START:  state_next = ST_CALC;
            ST_CALC:   if (sts.calc_done) state_next = ST_FINISH;
            ST_FINISH: if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.clear_we = (state_reg == ST_CLEAR);
        cmd.in_ready = (state_reg == ST_IDLE);
        cmd.capture  = (state_reg == ST_IDLE) && in_valid;
        cmd.prep     = (state_reg == ST_PREP);
        cmd.num      = (state_reg == ST_NUM);
        cmd.start    = (state_reg == ST_START);
        cmd.calc     = (state_reg == ST_CALC);
        cmd.finish   = (state_reg == ST_FINISH) && sts.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/bsb_dp.sv
// bsb_dp: background store, running-mean divider, shared-multiplier iir and output register
// depends on bsb_pkg, bsb_ram, bsb_div
module bsb_dp
    import bsb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                       in_frame_end,
    input  logic                       cfg_valid,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COEF_W-1:0]          cfg_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_filtered,
    output logic                       out_frame_done
);

    localparam logic signed [XH_W-1:0] X_MAX = {1'b0, {(XH_W-1){1'b1}}};
    localparam logic signed [XH_W-1:0] X_MIN = {1'b1, {(XH_W-1){1'b0}}};
    localparam logic signed [YH_W-1:0] Y_MAX = {1'b0, {(YH_W-1){1'b1}}};
    localparam logic signed [YH_W-1:0] Y_MIN = {1'b1, {(YH_W-1){1'b0}}};

    // clamp and truncate toward zero, fraction of 8 or 16 bits
    function automatic logic signed [SAMPLE_W-1:0] to_out(input logic signed [YH_W-1:0] v,
                                                          input logic frac8);
        logic [YH_W:0] lim;
        logic [YH_W:0] mag;
        logic [YH_W:0] sh;
        lim = frac8 ? (YH_W+1)'(CLAMP_POS * 256) : (YH_W+1)'(CLAMP_POS * 65536);
        mag = v[YH_W-1] ? ((YH_W+1)'(0) - {v[YH_W-1], v}) : {1'b0, v};
        sh  = frac8 ? (mag >> 8) : (mag >> 16);
        if (mag >= lim)
        begin
            to_out = v[YH_W-1] ? SAMPLE_W'(-CLAMP_POS) : SAMPLE_W'(CLAMP_POS);
        end
        else
        begin
            to_out = v[YH_W-1] ? $signed(SAMPLE_W'(0) - sh[SAMPLE_W-1:0])
                               : $signed(sh[SAMPLE_W-1:0]);
        end
    endfunction

    // configuration registers
    logic signed [COEF_W-1:0] coef_reg [7];
    logic [WIN_W-1:0]         bgf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
            begin
                coef_reg[i] <= '0;
            end
            bgf_reg <= WIN_W'(16);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COEF_B0, REG_COEF_B1, REG_COEF_B2, REG_COEF_A1,
                REG_COEF_A2, REG_COEF_A3, REG_COEF_A4:
                    coef_reg[cfg_index] <= $signed(cfg_data);
                REG_BG_FRAMES:
                    bgf_reg <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // clearing pass and frame position
    logic [BIN_W-1:0]  clr_reg;
    logic [BIN_W-1:0]  bin_reg;
    logic [FCNT_W-1:0] fcnt_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic              end_reg;

    logic [WIN_W-1:0]  win;
    logic [FCNT_W-1:0] n_val;
    logic              n_le_w;
    logic [WIN_W-1:0]  m_val;
    logic              last;

    assign win    = (bgf_reg == '0) ? WIN_W'(1) : bgf_reg;
    assign n_val  = fcnt_reg + 1'b1;
    assign n_le_w = n_val <= {1'b0, win};
    assign m_val  = n_le_w ? n_val[WIN_W-1:0] : win;
    assign last   = end_reg || (bin_reg == BIN_W'(BINS_PER_FRAME - 1));

    // background store
    logic                   ram_we;
    logic [BIN_W-1:0]       ram_addr;
    logic [BG_W-1:0]        ram_wdata;
    logic [BG_W-1:0]        ram_rdata;
    logic signed [BG_W-1:0] quot;

    assign ram_we    = cmd.clear_we || cmd.finish;
    assign ram_addr  = cmd.clear_we ? clr_reg : bin_reg;
    assign ram_wdata = cmd.clear_we ? '0 : quot;

    bsb_ram #(
        .WIDTH(BG_W),
        .DEPTH(BINS_PER_FRAME)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // difference and running-mean numerator
    logic signed [BG_W:0]     diff;
    logic signed [BG_W:0]     diff7;
    logic signed [XH_W-1:0]   x_reg;
    logic signed [NUM_W-1:0]  prodm_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [WIN_W-1:0]         m_reg;
    logic [WIN_W-1:0]         m_minus1;
    logic [DIV_W-1:0]         num_mag;
    logic                     div_busy;

    assign diff     = $signed({{2{sample_reg[SAMPLE_W-1]}}, sample_reg, 15'd0})
                    - $signed({ram_rdata[BG_W-1], ram_rdata});
    assign diff7    = diff >>> 7;
    assign m_minus1 = m_val - 1'b1;
    assign num_mag  = num_reg[NUM_W-1] ? DIV_W'(NUM_W'(0) - num_reg) : DIV_W'(num_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= in_sample;
            end_reg    <= in_frame_end;
        end
        if (cmd.prep)
        begin
            if (diff7 > (BG_W+1)'(X_MAX))
                x_reg <= X_MAX;
            else if (diff7 < (BG_W+1)'(X_MIN))
                x_reg <= X_MIN;
            else
                x_reg <= diff7[XH_W-1:0];
            prodm_reg <= NUM_W'($signed(ram_rdata)) * NUM_W'($signed({1'b0, m_minus1}));
            m_reg     <= m_val;
        end
        if (cmd.num)
        begin
            num_reg <= prodm_reg + $signed({{(NUM_W-SAMPLE_W-15){sample_reg[SAMPLE_W-1]}},
                                            sample_reg, 15'd0});
        end
    end

    bsb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .dividend (num_mag),
        .neg      (num_reg[NUM_W-1]),
        .divisor  (m_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    // iir: each term is two half-coefficient products on one multiplier
    logic signed [XH_W-1:0]  xh_reg [4];
    logic signed [YH_W-1:0]  yh_reg [4];
    logic [4:0]              cnt_reg;
    logic [3:0]              term_k;
    logic [3:0]              p_k;
    logic signed [OPA_W-1:0] opa;
    logic signed [COEF_W-1:0] cf;
    logic signed [OPB_W-1:0] opb;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    p_v_reg;
    logic [4:0]              p_op_reg;
    logic signed [PROD_W-16:0] lo_reg;
    logic signed [PROD_W-1:0] sum;
    logic signed [PROD_W-1:0] term_reg;
    logic                    t_v_reg;
    logic                    t_sub_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [YH_W-1:0]  y_sat;

    assign term_k = cnt_reg[4:1];
    assign p_k    = p_op_reg[4:1];

    always_comb
    begin
        case (term_k)
            4'd0:    opa = OPA_W'(x_reg);
            4'd1:    opa = OPA_W'(xh_reg[0]);
            4'd2:    opa = OPA_W'(xh_reg[1]);
            4'd3:    opa = OPA_W'(xh_reg[2]);
            4'd4:    opa = OPA_W'(xh_reg[3]);
            4'd5:    opa = yh_reg[0];
            4'd6:    opa = yh_reg[1];
            4'd7:    opa = yh_reg[2];
            4'd8:    opa = yh_reg[3];
            default: opa = '0;
        endcase
        case (term_k)
            4'd0, 4'd4: cf = coef_reg[REG_COEF_B0];
            4'd1, 4'd3: cf = coef_reg[REG_COEF_B1];
            4'd2:       cf = coef_reg[REG_COEF_B2];
            4'd5:       cf = coef_reg[REG_COEF_A1];
            4'd6:       cf = coef_reg[REG_COEF_A2];
            4'd7:       cf = coef_reg[REG_COEF_A3];
            4'd8:       cf = coef_reg[REG_COEF_A4];
            default:    cf = '0;
        endcase
        // odd op takes the signed upper half, even op the unsigned lower half
        opb = cnt_reg[0] ? $signed({cf[COEF_W-1], cf[COEF_W-1:16]})
                         : $signed({1'b0, cf[15:0]});
    end

    assign sum = prod_reg + PROD_W'(lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            p_v_reg <= 1'b0;
            t_v_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            cnt_reg <= '0;
            p_v_reg <= 1'b0;
            t_v_reg <= 1'b0;
        end
        else if (cmd.calc)
        begin
            if (cnt_reg != 5'(FILT_LAST))
                cnt_reg <= cnt_reg + 1'b1;
            p_v_reg <= cnt_reg < 5'(MUL_OPS);
            t_v_reg <= p_v_reg && p_op_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        if (cmd.calc)
        begin
            prod_reg <= opa * opb;
            p_op_reg <= cnt_reg;
            if (p_v_reg && !p_op_reg[0])
                lo_reg <= (PROD_W-15)'(prod_reg >>> 16);
            if (p_v_reg && p_op_reg[0])
            begin
                term_reg  <= (p_k < 4'd5) ? (sum >>> 4) : (sum >>> 12);
                t_sub_reg <= p_k >= 4'd5;
            end
            if (t_v_reg)
                acc_reg <= t_sub_reg ? acc_reg - ACC_W'(term_reg)
                                     : acc_reg + ACC_W'(term_reg);
        end
    end

    assign y_sat = (acc_reg > ACC_W'(Y_MAX)) ? Y_MAX :
                   (acc_reg < ACC_W'(Y_MIN)) ? Y_MIN : acc_reg[YH_W-1:0];

    // result, history and position update
    logic                       pass;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_filt_reg;
    logic                       out_done_reg;

    assign pass = bin_reg < BIN_W'(PASS_BINS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            bin_reg       <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear_we)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (pass)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        xh_reg[i] <= '0;
                        yh_reg[i] <= '0;
                    end
                end
                else
                begin
                    for (int i = 3; i > 0; i--)
                    begin
                        xh_reg[i] <= xh_reg[i-1];
                        yh_reg[i] <= yh_reg[i-1];
                    end
                    xh_reg[0] <= x_reg;
                    yh_reg[0] <= y_sat;
                end
                if (last)
                begin
                    bin_reg  <= '0;
                    fcnt_reg <= n_le_w ? n_val : FCNT_W'(SETTLED_COUNT);
                end
                else
                begin
                    bin_reg <= bin_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_filt_reg <= pass ? to_out(YH_W'(x_reg), 1'b1) : to_out(y_sat, 1'b0);
            out_done_reg <= last;
        end
    end

    assign sts.clear_last = clr_reg == BIN_W'(BINS_PER_FRAME - 1);
    assign sts.calc_done  = (cnt_reg == 5'(FILT_LAST)) && !div_busy;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_filtered   = out_filt_reg;
    assign out_frame_done = out_done_reg;

endmodule

// File: rtl/core/background_subtract_bandpass_unit.sv
// background_subtract_bandpass_unit: top level, joins controller and datapath
// depends on bsb_pkg, bsb_if, bsb_ctrl, bsb_dp
// one sample at a time: samples.ready is high only while idle, and each sample waits for the
// 43-step background divider and for room in the output register before the next is taken
// reset: registers and history cleared at once; then a clearing pass over all 2048 bins
// zeroes the background store while samples.ready stays low (register writes accepted)
module background_subtract_bandpass_unit
    import bsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bsb_in_if.sink      samples,
    bsb_out_if.source   results,
    bsb_cfg_if.sink     cfg
);

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready     = 1'b1;
    assign samples.ready = cmd.in_ready;

    bsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsb_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_sample      (samples.sample),
        .in_frame_end   (samples.frame_end),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .out_filtered   (results.filtered),
        .out_frame_done (results.frame_done)
    );

endmodule

// File: rtl/core/bsb_checker.sv
// bsb_checker: port-level assertions for the unit, bound to the top level
// depends on bsb_pkg
module bsb_checker
    import bsb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SAMPLE_W-1:0] out_filtered,
    input logic                out_frame_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_filtered)
                                    && $stable(out_frame_done))
        else $error("result changed while stalled");

    // result stays within the clamp
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(out_filtered) <= CLAMP_POS)
                      && ($signed(out_filtered) >= -CLAMP_POS))
        else $error("result outside clamp");

    // one sample in flight: no new transaction right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while busy");

    // clearing pass holds off samples after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("sample accepted during clearing pass");

endmodule

bind background_subtract_bandpass_unit bsb_checker u_bsb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (samples.valid),
    .in_ready       (samples.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_filtered   (results.filtered),
    .out_frame_done (results.frame_done)
);
